FILE: rtl/core/teq_pkg.sv
// Shared types and constants of the timed event queue.
package teq_pkg;

	localparam int SLOTS_DEF       = 16;
	localparam int MAX_PAYLOAD_DEF = 8;
	localparam int RESULT_CAP      = 16;
	localparam int IN_TDATA_W      = 224;
	localparam int OUT_TDATA_W     = 248;

	localparam logic [1:0] FUNC_SCHEDULE = 2'd0;
	localparam logic [1:0] FUNC_CANCEL   = 2'd1;
	localparam logic [1:0] FUNC_DISPATCH = 2'd2;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_ARG    = 3'd1,
		ST_FULL       = 3'd2,
		ST_BAD_HANDLE = 3'd3,
		ST_TOO_SMALL  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_SCHED,
		OP_CANCEL,
		OP_DISP,
		OP_BAD
	} op_t;

	typedef struct packed {
		op_t          op;
		logic [63:0]  tick;
		logic [7:0]   etype;
		logic [31:0]  src;
		logic [63:0]  payload;
		logic [3:0]   plen;
		logic [7:0]   hslot;
		logic [31:0]  hgen;
		logic [4:0]   limit;
	} cmd_t;

	typedef struct packed {
		status_t      status;
		logic         event_valid;
		logic [3:0]   slot;
		logic [31:0]  generation;
		logic [63:0]  ev_due;
		logic [31:0]  sequence_res;
		logic [7:0]   out_type;
		logic [31:0]  out_source;
		logic [63:0]  out_payload;
		logic [3:0]   out_payload_len;
		logic [4:0]   active;
		logic         last;
	} res_t;

endpackage

FILE: rtl/core/teq_front.sv
// Front end: takes input beats, classifies them and queues commands.
module teq_front #(
	parameter int MAX_PAYLOAD = teq_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [teq_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic [1:0]                        s_tuser,
	output teq_pkg::cmd_t                     cmd,
	output logic                              cmd_valid,
	input  logic                              cmd_pop
);
	import teq_pkg::*;

	cmd_t        fifo_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	cmd_t        dec;
	logic        push;
	logic [7:0]  len_in;
	logic [4:0]  max_in;
	logic [63:0] mask;

	always_comb begin
		len_in = s_tdata[175:168];
		max_in = s_tdata[220:216];
		for (int b = 0; b < 8; b++) begin
			mask[b*8 +: 8] = (b < int'(len_in)) ? 8'hFF : 8'h00;
		end
		dec.tick    = s_tdata[63:0];
		dec.etype   = s_tdata[71:64];
		dec.src     = s_tdata[103:72];
		dec.payload = s_tdata[167:104] & mask;
		dec.plen    = len_in[3:0];
		dec.hslot   = s_tdata[183:176];
		dec.hgen    = s_tdata[215:184];
		dec.limit   = (max_in > 5'(RESULT_CAP)) ? 5'(RESULT_CAP) : max_in;
		case (s_tuser)
			FUNC_SCHEDULE: begin
				// Argument errors take precedence over a full table.
				if (len_in > 8'(MAX_PAYLOAD) || dec.src == 32'd0) dec.op = OP_BAD;
				else dec.op = OP_SCHED;
			end
			FUNC_CANCEL:   dec.op = OP_CANCEL;
			FUNC_DISPATCH: dec.op = OP_DISP;
			default:       dec.op = OP_BAD;
		endcase
	end

	assign s_tready  = (count_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (cmd_pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule

FILE: rtl/core/teq_engine.sv
// Back end: slot table, per-command sequencer and result register.
module teq_engine #(
	parameter int SLOTS = teq_pkg::SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  teq_pkg::cmd_t  cmd,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	output teq_pkg::res_t  res,
	output logic           res_valid,
	input  logic           res_ready
);
	import teq_pkg::*;

	localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ACW = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {S_IDLE, S_RD, S_EXEC, S_SCAN, S_FETCH, S_DECIDE} state_t;

	state_t          state_q;
	cmd_t            cmd_q;
	logic [SLOTS-1:0] occ_q;
	logic [ACW-1:0]  active_q;
	logic [31:0]     next_seq_q;
	logic [31:0]     gen_q [SLOTS];
	logic [63:0]     due_mem [SLOTS];
	logic [31:0]     seq_mem [SLOTS];
	logic [7:0]      type_mem [SLOTS];
	logic [31:0]     src_mem [SLOTS];
	logic [63:0]     pay_mem [SLOTS];
	logic [3:0]      len_mem [SLOTS];

	logic [SIW-1:0]  raddr;
	logic [63:0]     rd_due_q, rd_pay_q;
	logic [31:0]     rd_seq_q, rd_src_q, rd_gen_q;
	logic [7:0]      rd_type_q;
	logic [3:0]      rd_len_q;
	logic [SIW-1:0]  rd_idx_s1;
	logic            scan_v_s1;

	logic [ACW-1:0]  ptr_q;
	logic            found_q;
	logic [SIW-1:0]  best_q;
	logic [63:0]     best_due_q;
	logic [31:0]     best_seq_q;
	logic [4:0]      n_q;
	res_t            pend_q;
	logic            pend_v_q;
	res_t            out_q;
	logic            out_valid_q;

	logic            out_free, any_free, can_ok, hit, take, wr_en, free_en, emit;
	logic [SIW-1:0]  fidx, hidx, free_idx;
	res_t            sch_res, ev_res, pend_more, pend_small;

	function automatic res_t plain_res(status_t st, logic [4:0] act);
		res_t r;
		r        = '0;
		r.status = st;
		r.active = act;
		r.last   = 1'b1;
		return r;
	endfunction

	assign hidx      = cmd_q.hslot[SIW-1:0];
	assign out_free  = !out_valid_q || res_ready;
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;
	assign res       = out_q;
	assign res_valid = out_valid_q;

	// Lowest free slot.
	always_comb begin
		fidx     = '0;
		any_free = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!occ_q[i]) begin
				fidx     = SIW'(i);
				any_free = 1'b1;
			end
		end
	end

	// The read address is held while a result waits, so the read data stays valid.
	always_comb begin
		case (state_q)
			S_RD, S_EXEC:     raddr = (cmd_q.op == OP_SCHED) ? fidx : hidx;
			S_FETCH, S_DECIDE: raddr = best_q;
			default:          raddr = ptr_q[SIW-1:0];
		endcase
	end

	always_comb begin
		can_ok  = (cmd_q.hslot < 8'(SLOTS)) && occ_q[hidx] && (rd_gen_q == cmd_q.hgen);
		hit     = (state_q == S_SCAN) && scan_v_s1 && occ_q[rd_idx_s1] &&
		          (rd_due_q <= cmd_q.tick) &&
		          (!found_q || rd_due_q < best_due_q ||
		           (rd_due_q == best_due_q && rd_seq_q < best_seq_q));
		take    = (state_q == S_DECIDE) && out_free && found_q && (n_q < cmd_q.limit);
		wr_en   = (state_q == S_EXEC) && out_free && (cmd_q.op == OP_SCHED) && any_free;
		free_en = ((state_q == S_EXEC) && out_free && (cmd_q.op == OP_CANCEL) && can_ok) ||
		          take;
		free_idx = (state_q == S_EXEC) ? hidx : best_q;
		emit    = out_free && ((state_q == S_EXEC) ||
		          ((state_q == S_DECIDE) &&
		           (!found_q || n_q >= cmd_q.limit || pend_v_q)));
	end

	// Result beats assembled from the current table read.
	always_comb begin
		sch_res             = plain_res(ST_OK, 5'(active_q + ACW'(1)));
		sch_res.event_valid = 1'b1;
		sch_res.slot        = 4'(fidx);
		sch_res.generation  = rd_gen_q;

		ev_res                 = plain_res(ST_OK, 5'(active_q - ACW'(1)));
		ev_res.event_valid     = 1'b1;
		ev_res.slot            = 4'(best_q);
		ev_res.generation      = rd_gen_q;
		ev_res.ev_due          = rd_due_q;
		ev_res.sequence_res    = rd_seq_q;
		ev_res.out_type        = rd_type_q;
		ev_res.out_source      = rd_src_q;
		ev_res.out_payload     = rd_pay_q;
		ev_res.out_payload_len = rd_len_q;

		pend_more      = pend_q;
		pend_more.last = 1'b0;

		pend_small        = pend_q;
		pend_small.status = ST_TOO_SMALL;
		pend_small.last   = 1'b1;
	end

	// Slot table storage and its single registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			due_mem[fidx]  <= cmd_q.tick;
			seq_mem[fidx]  <= next_seq_q;
			type_mem[fidx] <= cmd_q.etype;
			src_mem[fidx]  <= cmd_q.src;
			pay_mem[fidx]  <= cmd_q.payload;
			len_mem[fidx]  <= cmd_q.plen;
		end
		rd_due_q  <= due_mem[raddr];
		rd_seq_q  <= seq_mem[raddr];
		rd_type_q <= type_mem[raddr];
		rd_src_q  <= src_mem[raddr];
		rd_pay_q  <= pay_mem[raddr];
		rd_len_q  <= len_mem[raddr];
		rd_gen_q  <= gen_q[raddr];
		rd_idx_s1 <= ptr_q[SIW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) gen_q[i] <= 32'd1;
		end else if (free_en) begin
			gen_q[free_idx] <= gen_q[free_idx] + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			occ_q       <= '0;
			active_q    <= '0;
			next_seq_q  <= 32'd1;
			scan_v_s1   <= 1'b0;
			ptr_q       <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			best_due_q  <= '0;
			best_seq_q  <= '0;
			n_q         <= '0;
			pend_q      <= '0;
			pend_v_q    <= 1'b0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) out_valid_q <= 1'b1;
			else if (res_ready) out_valid_q <= 1'b0;
			if (wr_en) begin
				occ_q[fidx] <= 1'b1;
				next_seq_q  <= next_seq_q + 32'd1;
				active_q    <= active_q + ACW'(1);
			end
			if (free_en) begin
				occ_q[free_idx] <= 1'b0;
				active_q        <= active_q - ACW'(1);
			end
			scan_v_s1 <= (state_q == S_SCAN) && (ptr_q < ACW'(SLOTS));
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q    <= cmd;
						ptr_q    <= '0;
						found_q  <= 1'b0;
						n_q      <= '0;
						pend_v_q <= 1'b0;
						case (cmd.op)
							OP_DISP: state_q <= S_SCAN;
							OP_BAD:  state_q <= S_EXEC;
							default: state_q <= S_RD;
						endcase
					end
				end
				S_RD: state_q <= S_EXEC;
				S_EXEC: begin
					if (out_free) begin
						state_q <= S_IDLE;
						case (cmd_q.op)
							OP_SCHED: begin
								if (any_free) out_q <= sch_res;
								else out_q <= plain_res(ST_FULL, 5'(active_q));
							end
							OP_CANCEL: begin
								if (can_ok) out_q <= plain_res(ST_OK, 5'(active_q - ACW'(1)));
								else out_q <= plain_res(ST_BAD_HANDLE, 5'(active_q));
							end
							default: out_q <= plain_res(ST_BAD_ARG, 5'(active_q));
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						found_q    <= 1'b1;
						best_q     <= rd_idx_s1;
						best_due_q <= rd_due_q;
						best_seq_q <= rd_seq_q;
					end
					ptr_q <= ptr_q + ACW'(1);
					if (ptr_q == ACW'(SLOTS)) state_q <= S_FETCH;
				end
				S_FETCH: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (out_free) begin
						if (found_q && n_q >= cmd_q.limit) begin
							// Another due entry is left over: flag the final beat.
							state_q <= S_IDLE;
							if (n_q == 5'd0) out_q <= plain_res(ST_TOO_SMALL, 5'(active_q));
							else out_q <= pend_small;
						end else if (found_q) begin
							if (pend_v_q) out_q <= pend_more;
							pend_q   <= ev_res;
							pend_v_q <= 1'b1;
							n_q      <= n_q + 5'd1;
							ptr_q    <= '0;
							found_q  <= 1'b0;
							state_q  <= S_SCAN;
						end else begin
							state_q <= S_IDLE;
							if (pend_v_q) out_q <= pend_q;
							else out_q <= plain_res(ST_OK, 5'(active_q));
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_active_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ_q) == int'(active_q))
		else $error("active count out of step with occupied slots");

	a_pend_counted: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> n_q != 5'd0)
		else $error("held dispatch result without a count");

	a_plain_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.event_valid) |-> out_q.last)
		else $error("result without an event is not the final beat");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> state_q != S_IDLE)
		else $error("command popped but sequencer stayed idle");

endmodule

FILE: rtl/core/timed_event_queue_top.sv
// Top level of the timed event queue: stream ports, front end and back end.
// The block keeps a table of SLOTS timed events. A schedule or cancel beat
// yields one result beat after the back end takes it from the command queue
// and steps through the read and execute states, a malformed beat through
// the execute state only. A dispatch scans the table one slot per cycle
// through the single read port of the slot table; every emitted event takes
// a full scan followed by the fetch and decide states, and no new command is
// taken until the dispatch is through. A two-beat command queue sits between
// the front end and the back end, and the result beat is held in an output
// register, so input beats are still taken while a result waits, until the
// command queue is full. Every dispatch result except the final one has
// tlast low. There is no clearing pass after reset.
module timed_event_queue_top #(
	parameter int SLOTS       = teq_pkg::SLOTS_DEF,
	parameter int MAX_PAYLOAD = teq_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// tick[63:0], event_type[71:64], source_id[103:72], payload_data[167:104],
	// payload_len[175:168], handle_slot[183:176], handle_gen[215:184],
	// max_events[220:216], zero fill above.
	input  logic [teq_pkg::IN_TDATA_W-1:0]    s_tdata,
	// func[1:0]
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// status[2:0], slot[6:3], generation[38:7], ev_due[102:39],
	// sequence_res[134:103], out_type[142:135], out_source[174:143],
	// out_payload[238:175], out_payload_len[242:239], active[247:243].
	output logic [teq_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// event_valid[0]
	output logic [0:0]                        m_tuser,
	output logic                              m_tlast
);
	import teq_pkg::*;

	cmd_t cmd;
	logic cmd_valid, cmd_pop;
	res_t res;

	teq_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	teq_engine #(.SLOTS(SLOTS)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.res       (res),
		.res_valid (m_tvalid),
		.res_ready (m_tready)
	);

	// Result beat packing, lowest field first.
	assign m_tdata = {res.active, res.out_payload_len, res.out_payload, res.out_source,
	                  res.out_type, res.sequence_res, res.ev_due, res.generation,
	                  res.slot, res.status};
	assign m_tuser = res.event_valid;
	assign m_tlast = res.last;

endmodule
